/* src/mbtf_pkg.sv */
// Shared types and codes of the memory block transfer framer.
// No dependencies; imported by every module of the block.
package mbtf_pkg;

  // Input action codes
  localparam logic [2:0] ACT_START = 3'd0;
  localparam logic [2:0] ACT_HOST  = 3'd1;
  localparam logic [2:0] ACT_LINK  = 3'd2;
  localparam logic [2:0] ACT_LFAIL = 3'd3;
  localparam logic [2:0] ACT_HFAIL = 3'd4;

  // Result kinds
  localparam logic [1:0] KIND_LINK = 2'd0;
  localparam logic [1:0] KIND_HOST = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  // Done status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_HOST_ERR = 2'd1;
  localparam logic [1:0] ST_LINK_ERR = 2'd2;
  localparam logic [1:0] ST_MISMATCH = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_DIRECTION = 3'd0;
  localparam logic [2:0] REG_MODE      = 3'd1;
  localparam logic [2:0] REG_BANK      = 3'd2;
  localparam logic [2:0] REG_OFFSET    = 3'd3;
  localparam logic [2:0] REG_LENGTH    = 3'd4;
  localparam logic [2:0] REG_SEED      = 3'd5;

  // Header command bytes
  localparam logic [7:0] CMD_WRITE = 8'h02;
  localparam logic [7:0] CMD_READ  = 8'h01;

  localparam int unsigned BurstMax = 8;

  typedef struct packed {
    logic        direction;
    logic [7:0]  mode_byte;
    logic [7:0]  bank_byte;
    logic [15:0] base_offset;
    logic [15:0] block_length;
    logic [15:0] crc_seed;
  } cfg_t;

  // Set of results caused by one accepted item
  typedef struct packed {
    logic [1:0]                 kind;
    logic [BurstMax-1:0][7:0]   bytes;
    logic [2:0]                 last_idx;
    logic [1:0]                 status;
    logic [15:0]                moved_count;
    logic [15:0]                crc_out;
  } burst_t;

endpackage

/* src/mbtf_cfg.sv */
// Configuration register file of the transfer framer.
// Depends on mbtf_pkg for register indexes and the cfg_t struct.
module mbtf_cfg import mbtf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_addr_i,
  input  logic [15:0] cfg_data_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_addr_i)
        REG_DIRECTION: cfg_d.direction    = cfg_data_i[0];
        REG_MODE:      cfg_d.mode_byte    = cfg_data_i[7:0];
        REG_BANK:      cfg_d.bank_byte    = cfg_data_i[7:0];
        REG_OFFSET:    cfg_d.base_offset  = cfg_data_i;
        REG_LENGTH:    cfg_d.block_length = cfg_data_i;
        REG_SEED:      cfg_d.crc_seed     = cfg_data_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

/* src/mbtf_core.sv */
// Transfer state machine: phase, checksum, CRC and byte count.
// Turns each accepted item into a result burst; depends on mbtf_pkg.
module mbtf_core import mbtf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       in_acc_i,
  input  logic [2:0] action_i,
  input  logic [7:0] data_byte_i,
  output logic       burst_valid_o,
  output burst_t     burst_o
);

  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_WDATA = 5'b00010,
    PH_WCHK  = 5'b00100,
    PH_RDATA = 5'b01000,
    PH_RCHK  = 5'b10000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  sum_q, sum_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] cnt_q, cnt_d;
  logic        hfail_q, hfail_d;

  logic        hfail_n;
  logic [7:0]  absorb_b;
  logic [7:0]  sum_n;
  logic [15:0] crc_n;
  logic [15:0] cnt_n;
  logic        len_zero;

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    return c;
  endfunction

  assign len_zero = (cfg_i.block_length == 16'd0);

  // Byte absorbed in a data phase: host data in write (zero after a host failure), link data in read
  always_comb begin
    hfail_n  = hfail_q | (action_i == ACT_HFAIL);
    absorb_b = data_byte_i;
    if (phase_q == PH_WDATA && hfail_n) begin
      absorb_b = 8'h00;
    end
    sum_n = sum_q + absorb_b + 8'd1;
    crc_n = crc_step(crc_q, absorb_b);
    cnt_n = cnt_q + 16'd1;
  end

  always_comb begin
    phase_d       = phase_q;
    sum_d         = sum_q;
    crc_d         = crc_q;
    cnt_d         = cnt_q;
    hfail_d       = hfail_q;
    burst_valid_o = 1'b0;
    burst_o       = '0;

    if (in_acc_i) begin
      case (phase_q)
        PH_IDLE: begin
          if (action_i == ACT_START) begin
            burst_valid_o  = 1'b1;
            burst_o.kind   = KIND_LINK;
            burst_o.bytes[0] = cfg_i.direction ? CMD_READ : CMD_WRITE;
            burst_o.bytes[1] = cfg_i.mode_byte;
            burst_o.bytes[2] = cfg_i.bank_byte;
            burst_o.bytes[3] = cfg_i.base_offset[7:0];
            burst_o.bytes[4] = cfg_i.base_offset[15:8];
            burst_o.bytes[5] = cfg_i.block_length[7:0];
            burst_o.bytes[6] = cfg_i.block_length[15:8];
            burst_o.last_idx = 3'd6;
            sum_d   = 8'h00;
            crc_d   = cfg_i.crc_seed;
            cnt_d   = 16'd0;
            hfail_d = 1'b0;
            if (cfg_i.direction) begin
              phase_d = len_zero ? PH_RCHK : PH_RDATA;
            end else if (len_zero) begin
              // empty write: checksum byte of zero follows the header
              burst_o.bytes[7] = 8'h00;
              burst_o.last_idx = 3'd7;
              phase_d = PH_WCHK;
            end else begin
              phase_d = PH_WDATA;
            end
          end
        end
        PH_WDATA: begin
          if (action_i == ACT_LFAIL) begin
            burst_valid_o       = 1'b1;
            burst_o.kind        = KIND_DONE;
            burst_o.status      = hfail_q ? ST_HOST_ERR : ST_LINK_ERR;
            burst_o.moved_count = cnt_q;
            burst_o.crc_out     = crc_q;
            phase_d             = PH_IDLE;
          end else if (action_i == ACT_HOST || action_i == ACT_HFAIL) begin
            burst_valid_o    = 1'b1;
            burst_o.kind     = KIND_LINK;
            burst_o.bytes[0] = absorb_b;
            hfail_d = hfail_n;
            sum_d   = sum_n;
            crc_d   = crc_n;
            cnt_d   = cnt_n;
            if (cnt_n >= cfg_i.block_length) begin
              burst_o.bytes[1] = sum_n;
              burst_o.last_idx = 3'd1;
              phase_d = PH_WCHK;
            end
          end
        end
        PH_RDATA: begin
          if (action_i == ACT_LFAIL) begin
            burst_valid_o       = 1'b1;
            burst_o.kind        = KIND_DONE;
            burst_o.status      = hfail_q ? ST_HOST_ERR : ST_LINK_ERR;
            burst_o.moved_count = cnt_q;
            burst_o.crc_out     = crc_q;
            phase_d             = PH_IDLE;
          end else if (action_i == ACT_LINK) begin
            burst_valid_o    = !hfail_q;
            burst_o.kind     = KIND_HOST;
            burst_o.bytes[0] = data_byte_i;
            sum_d = sum_n;
            crc_d = crc_n;
            cnt_d = cnt_n;
            if (cnt_n >= cfg_i.block_length) begin
              phase_d = PH_RCHK;
            end
          end else if (action_i == ACT_HFAIL) begin
            hfail_d = 1'b1;
          end
        end
        PH_WCHK, PH_RCHK: begin
          if (action_i == ACT_LFAIL || action_i == ACT_LINK) begin
            burst_valid_o       = 1'b1;
            burst_o.kind        = KIND_DONE;
            burst_o.moved_count = cnt_q;
            burst_o.crc_out     = crc_q;
            if (hfail_q) begin
              burst_o.status = ST_HOST_ERR;
            end else if (action_i == ACT_LFAIL) begin
              burst_o.status = ST_LINK_ERR;
            end else begin
              burst_o.status = (data_byte_i == sum_q) ? ST_OK : ST_MISMATCH;
            end
            phase_d = PH_IDLE;
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      sum_q   <= 8'h00;
      crc_q   <= 16'h0000;
      cnt_q   <= 16'd0;
      hfail_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      sum_q   <= sum_d;
      crc_q   <= crc_d;
      cnt_q   <= cnt_d;
      hfail_q <= hfail_d;
    end
  end

endmodule

/* src/mbtf_out.sv */
// Result register and burst sequencer: emits the results of each burst one at a time.
// Depends on mbtf_pkg for the burst_t struct and result kinds.
module mbtf_out import mbtf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        burst_valid_i,
  input  burst_t      burst_i,
  output logic        load_ready_o,
  output logic        m_valid_o,
  input  logic        m_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  out_byte_o,
  output logic [1:0]  status_o,
  output logic [15:0] moved_count_o,
  output logic [15:0] crc_out_o,
  output logic        last_o
);

  burst_t     burst_q;
  logic       valid_q, valid_d;
  logic [2:0] idx_q, idx_d;
  logic       take;
  logic       at_last;

  assign take         = valid_q && m_ready_i;
  assign at_last      = (idx_q == burst_q.last_idx);
  assign load_ready_o = !valid_q || (take && at_last);

  assign m_valid_o     = valid_q;
  assign kind_o        = burst_q.kind;
  assign out_byte_o    = burst_q.bytes[idx_q];
  assign status_o      = burst_q.status;
  assign moved_count_o = burst_q.moved_count;
  assign crc_out_o     = burst_q.crc_out;
  assign last_o        = at_last;

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load_ready_o && burst_valid_i) begin
      valid_d = 1'b1;
      idx_d   = 3'd0;
    end else if (take) begin
      // advance through the burst, drop it after its final result
      if (at_last) begin
        valid_d = 1'b0;
      end else begin
        idx_d = idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 3'd0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_ready_o && burst_valid_i) begin
      burst_q <= burst_i;
    end
  end

endmodule

/* src/mem_block_transfer_framer.sv */
// Top level of the memory block transfer framer.
// Depends on mbtf_pkg, mbtf_cfg, mbtf_core and mbtf_out.
//
//  Channel  Direction  Handshake                   Payload
//  s_axis   in         s_axis_tvalid/tready        tuser: action; tdata: data_byte
//  m_axis   out        m_axis_tvalid/tready        tuser: kind; tdata: byte/status/
//                                                   count/crc; tlast: last
//  cfg      in         cfg_valid_i/cfg_ready_o     cfg_addr_i index, cfg_data_i value
//
// The state logic between the input port and the result register settles in the
// cycle that takes an item. An item causing several results blocks the input until
// its last result is taken: the result register emits one result per cycle while
// m_axis is ready (a start gives 7 or 8 results, a data byte at most 2). An item
// arriving with the last result of the previous burst is taken in that same cycle.
// Reset sets phase idle and accumulators, configuration and control registers to
// zero (not the result data); no clearing pass. A stall on m_axis holds the current
// result and blocks s_axis once its burst is pending.
module mem_block_transfer_framer import mbtf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [2:0]  s_axis_tuser,   // [2:0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [7:0] out_byte, [9:8] status,
                                      // [25:10] moved_count, [41:26] crc_out, zero above
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_addr_i,
  input  logic [15:0] cfg_data_i
);

  cfg_t        cfg;
  logic        in_acc;
  logic        burst_valid;
  burst_t      burst;
  logic        load_ready;
  logic [7:0]  out_byte;
  logic [1:0]  status;
  logic [15:0] moved_count;
  logic [15:0] crc_out;

  assign s_axis_tready = load_ready;
  assign in_acc        = s_axis_tvalid && load_ready;

  mbtf_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  mbtf_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_acc_i      (in_acc),
    .action_i      (s_axis_tuser),
    .data_byte_i   (s_axis_tdata),
    .burst_valid_o (burst_valid),
    .burst_o       (burst)
  );

  mbtf_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .burst_valid_i (burst_valid),
    .burst_i       (burst),
    .load_ready_o  (load_ready),
    .m_valid_o     (m_axis_tvalid),
    .m_ready_i     (m_axis_tready),
    .kind_o        (m_axis_tuser),
    .out_byte_o    (out_byte),
    .status_o      (status),
    .moved_count_o (moved_count),
    .crc_out_o     (crc_out),
    .last_o        (m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, crc_out, moved_count, status, out_byte};

  // Input is never blocked while no result is pending
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty result register");

  // A done result always closes its burst
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == KIND_DONE) |-> m_axis_tlast)
    else $error("done result not marked last");

  // Byte results carry no status, count or CRC
  a_byte_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != KIND_DONE) |-> (m_axis_tdata[47:8] == 40'd0))
    else $error("byte result with nonzero done fields");

  // A burst still pending with more results keeps the input stalled
  a_hold_mid_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> !s_axis_tready)
    else $error("input taken in the middle of a burst");

endmodule
